### design/bole_pkg.sv
// Shared types, constants and helpers of the bounded ordered list engine.
package bole_pkg;

    // List geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Stream widths
    localparam int IN_W  = 48;
    localparam int OUT_W = 48;

    // Operation codes
    localparam logic [3:0] OP_PUSH_FRONT   = 4'd0;
    localparam logic [3:0] OP_PUSH_BACK    = 4'd1;
    localparam logic [3:0] OP_POP_FRONT    = 4'd2;
    localparam logic [3:0] OP_POP_BACK     = 4'd3;
    localparam logic [3:0] OP_INSERT_AT    = 4'd4;
    localparam logic [3:0] OP_REPLACE_AT   = 4'd5;
    localparam logic [3:0] OP_REMOVE_AT    = 4'd6;
    localparam logic [3:0] OP_INSERT_SORTED = 4'd7;
    localparam logic [3:0] OP_FIND         = 4'd8;
    localparam logic [3:0] OP_CLEAR        = 4'd9;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Cell update modes
    localparam logic [1:0] CM_NONE = 2'd0;
    localparam logic [1:0] CM_INS  = 2'd1;
    localparam logic [1:0] CM_DEL  = 2'd2;
    localparam logic [1:0] CM_WR   = 2'd3;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic              cmp;
        logic [1:0]        mode;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  value;
    } t_cell_cmd;

    // Result of a first-set search
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_first;

    // Find the lowest set flag
    function automatic t_first first_set(input logic [DEPTH-1:0] flags);
        t_first res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (flags[i]) begin
                res.found = 1'b1;
                res.idx   = IDX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

### design/bole_cell.sv
// One list cell: holds an element, shifts with its neighbors and compares.
module bole_cell (
    input  logic                        i_clk,
    input  logic [bole_pkg::IDX_W-1:0]  i_pos,
    input  bole_pkg::t_cell_cmd         i_cmd,
    input  logic [bole_pkg::VAL_W-1:0]  i_left,
    input  logic [bole_pkg::VAL_W-1:0]  i_right,
    output logic [bole_pkg::VAL_W-1:0]  o_value,
    output logic                        o_eq,
    output logic                        o_gt
);
    import bole_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic             r_eq;
    logic             r_gt;

    // Capture compare flags against the request value
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_eq <= (r_value == i_cmd.value);
            r_gt <= ($signed(r_value) > $signed(i_cmd.value));
        end
    end

    // Shift, load or hold the element
    always_ff @(posedge i_clk) begin
        case (i_cmd.mode)
            CM_INS: begin
                if (i_pos > i_cmd.idx) begin
                    r_value <= i_left;
                end else if (i_pos == i_cmd.idx) begin
                    r_value <= i_cmd.value;
                end
            end
            CM_DEL: begin
                if (i_pos >= i_cmd.idx) begin
                    r_value <= i_right;
                end
            end
            CM_WR: begin
                if (i_pos == i_cmd.idx) begin
                    r_value <= i_cmd.value;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_value = r_value;
    assign o_eq    = r_eq;
    assign o_gt    = r_gt;

endmodule

### design/bounded_ordered_list_engine_unit.sv
// Top level of the bounded ordered list engine: control, cell chain and output register.
//
// Usage: requests arrive on the slave stream (i_s_tvalid / o_s_tready /
// i_s_tdata) and each one yields exactly one result on the master stream
// (o_m_tvalid / i_m_tready / o_m_tdata). A request carries an operation
// code, a value and a position; the result carries a status, the value
// removed, the index found and the element count after the operation.
// Timing: an accepted request passes through a compare step, in which
// every cell compares its element with the request value, and then an
// execute step that picks the target index, shifts the chain and loads
// the result. One request is worked on at a time, so a new request is
// taken only after the previous one has left the execute step. The result
// register frees the input side, so the next request is accepted while a
// result still waits.
// Stall: while the receiver holds i_m_tready low, a finished result
// stays in the output register and the next request waits in the
// execute step without touching the list.
// Reset: synchronous, active low; clears the element count and all
// handshake state. Element contents are not cleared.
module bounded_ordered_list_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [3:0] operation, [35:4] item_value, [40:36] position, [47:41] zero
    input  logic [bole_pkg::IN_W-1:0]     i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [2:0] status, [34:3] result_value, [38:35] result_index,
    // [43:39] element_count, [47:44] zero
    output logic [bole_pkg::OUT_W-1:0]    o_m_tdata
);
    import bole_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [3:0]        r_op;
    logic [VAL_W-1:0]  r_val;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_m_valid;
    logic [OUT_W-1:0]  r_m_data;

    logic              s_accept;
    logic              exec_go;
    t_cell_cmd         cmd;
    logic [VAL_W-1:0]  cell_value [DEPTH];
    logic [DEPTH-1:0]  cell_eq;
    logic [DEPTH-1:0]  cell_gt;
    logic [DEPTH-1:0]  valid_mask;
    t_first            eq_first;
    t_first            gt_first;

    logic [1:0]        ex_mode;
    logic [IDX_W-1:0]  ex_idx;
    logic [2:0]        ex_status;
    logic              ex_take;
    logic [IDX_W-1:0]  ex_ri;
    logic [VAL_W-1:0]  ex_rv;

    // Input handshake
    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign exec_go    = (r_state == S_EXEC) && (!r_m_valid || i_m_tready);

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op  <= i_s_tdata[3:0];
            r_val <= i_s_tdata[35:4];
            r_pos <= i_s_tdata[40:36];
        end
    end

    // Sequence the request through compare and execute
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Cell chain
    assign cmd.cmp   = (r_state == S_CMP);
    assign cmd.mode  = exec_go ? ex_mode : CM_NONE;
    assign cmd.idx   = ex_idx;
    assign cmd.value = r_val;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] left_v;
        logic [VAL_W-1:0] right_v;

        if (g == 0) begin : g_first
            assign left_v = cell_value[g];
        end else begin : g_mid_l
            assign left_v = cell_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_v = cell_value[g];
        end else begin : g_mid_r
            assign right_v = cell_value[g+1];
        end

        assign valid_mask[g] = (CNT_W'(g) < r_count);

        bole_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (IDX_W'(g)),
            .i_cmd   (cmd),
            .i_left  (left_v),
            .i_right (right_v),
            .o_value (cell_value[g]),
            .o_eq    (cell_eq[g]),
            .o_gt    (cell_gt[g])
        );
    end

    // First match and first larger element among stored entries
    assign eq_first = first_set(cell_eq & valid_mask);
    assign gt_first = first_set(cell_gt & valid_mask);

    // Decode the operation against count and flags
    always_comb begin
        logic             full;
        logic             empty;
        logic [CMP_W-1:0] pos_x;
        logic [CMP_W-1:0] cnt_x;

        full      = (r_count == CNT_W'(DEPTH));
        empty     = (r_count == '0);
        pos_x     = CMP_W'(r_pos);
        cnt_x     = CMP_W'(r_count);
        ex_mode   = CM_NONE;
        ex_idx    = '0;
        ex_status = ST_OK;
        ex_take   = 1'b0;
        ex_ri     = '0;
        n_count   = r_count;

        case (r_op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (full) begin
                    ex_status = ST_FULL;
                end else begin
                    ex_mode = CM_INS;
                    ex_idx  = (r_op == OP_PUSH_FRONT) ? '0 : IDX_W'(r_count);
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (empty) begin
                    ex_status = ST_EMPTY;
                end else begin
                    ex_mode = CM_DEL;
                    ex_take = 1'b1;
                    ex_idx  = (r_op == OP_POP_FRONT) ? '0 :
                              IDX_W'(r_count - CNT_W'(1));
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_INSERT_AT: begin
                if (full) begin
                    ex_status = ST_FULL;
                end else if (pos_x > cnt_x) begin
                    ex_status = ST_BADPOS;
                end else begin
                    ex_mode = CM_INS;
                    ex_idx  = IDX_W'(r_pos);
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REPLACE_AT: begin
                if (pos_x < cnt_x) begin
                    ex_mode = CM_WR;
                    ex_idx  = IDX_W'(r_pos);
                end else if (pos_x > cnt_x) begin
                    ex_status = ST_BADPOS;
                end else if (full) begin
                    ex_status = ST_FULL;
                end else begin
                    ex_mode = CM_INS;
                    ex_idx  = IDX_W'(r_pos);
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE_AT: begin
                if (empty) begin
                    ex_status = ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    ex_status = ST_BADPOS;
                end else begin
                    ex_mode = CM_DEL;
                    ex_take = 1'b1;
                    ex_idx  = IDX_W'(r_pos);
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_INSERT_SORTED: begin
                if (full) begin
                    ex_status = ST_FULL;
                end else begin
                    ex_mode = CM_INS;
                    ex_idx  = gt_first.found ? gt_first.idx : IDX_W'(r_count);
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_FIND: begin
                if (eq_first.found) begin
                    ex_ri = eq_first.idx;
                end else begin
                    ex_status = ST_NOTFOUND;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Read the element being taken out
    assign ex_rv = ex_take ? cell_value[ex_idx] : '0;

    // Advance the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (exec_go) begin
            r_count <= n_count;
        end
    end

    // Output register: load on execute, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (exec_go) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_m_data <= {4'd0, 5'(n_count), 4'(ex_ri), ex_rv, ex_status};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec_go |=> $stable(r_count))
        else $error("element count changed outside execute");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_EXEC))
        else $error("result shown without execute step");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_CMP))
        else $error("accepted request did not enter compare");
`endif

endmodule
